### rtl/core/assert_macros.svh
// Assertion helpers shared by the plotter RTL.
// Both take the clock and an active-low reset by their usual names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define WCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must imply a property.
`define WCP_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

### rtl/core/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Types and constants of the waveform column plotter.
// ----------------------------------------------------------------------------
package wcp_pkg;

  localparam int unsigned PAGES   = 8;
  localparam int unsigned COLUMNS = 128;
  localparam int unsigned PAGE_W  = 3;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned Y_W     = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
  localparam logic [2:0]        BIT_TOP   = 3'd7;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [Y_W-1:0]   sample;
  } in_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  out_column;
    logic [BYTE_W-1:0] pixels;
    logic              last;
  } out_t;

  // One classified sample: line runs from hi_page down to lo_page.
  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [PAGE_W-1:0] hi_page;
    logic [PAGE_W-1:0] lo_page;
    logic [BYTE_W-1:0] hi_byte;
    logic [BYTE_W-1:0] lo_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINE,
    ST_CLEAR
  } back_state_e;

endpackage

### rtl/core/wcp_front.sv
// ----------------------------------------------------------------------------
// wcp_front
// Accepts samples, works out page and mask and classifies the line segment.
// ----------------------------------------------------------------------------
module wcp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wcp_pkg::in_t        in_data_i,
  input  wcp_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output wcp_pkg::cmd_t       cmd_o
);

  logic [wcp_pkg::PAGE_W-1:0] prev_page_q, prev_page_d;
  logic [2:0]                 prev_shift_q, prev_shift_d;
  logic [wcp_pkg::BYTE_W-1:0] prev_mask_q, prev_mask_d;

  logic [wcp_pkg::PAGE_W-1:0] band;
  logic [wcp_pkg::PAGE_W-1:0] cur_page;
  logic [2:0]                 cur_shift;
  logic [wcp_pkg::BYTE_W-1:0] cur_mask;
  logic [3:0]                 up_shift;
  logic [wcp_pkg::BYTE_W-1:0] same_byte;

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    band = in_data_i.sample[wcp_pkg::Y_W-1:3];
    if (band > wcp_pkg::LAST_PAGE) begin
      band = wcp_pkg::LAST_PAGE;
    end
    cur_page  = wcp_pkg::LAST_PAGE - band;
    cur_shift = wcp_pkg::BIT_TOP - in_data_i.sample[2:0];
    cur_mask  = wcp_pkg::BYTE_ONE << cur_shift;
    up_shift  = {1'b0, prev_shift_q} + 4'd1;

    if (cur_shift == prev_shift_q) begin
      same_byte = cur_mask;
    end else if (cur_shift > prev_shift_q) begin
      same_byte = (cur_mask - prev_mask_q) | cur_mask;
    end else begin
      same_byte = prev_mask_q - cur_mask;
    end

    cmd_o.column = in_data_i.column;
    if (prev_page_q > cur_page) begin
      cmd_o.hi_page = prev_page_q;
      cmd_o.lo_page = cur_page;
      cmd_o.hi_byte = prev_mask_q - wcp_pkg::BYTE_ONE;
      cmd_o.lo_byte = wcp_pkg::BYTE_ONES << cur_shift;
    end else if (prev_page_q == cur_page) begin
      cmd_o.hi_page = cur_page;
      cmd_o.lo_page = cur_page;
      cmd_o.hi_byte = same_byte;
      cmd_o.lo_byte = same_byte;
    end else begin
      cmd_o.hi_page = cur_page;
      cmd_o.lo_page = prev_page_q;
      cmd_o.hi_byte = (cur_mask << 1) - wcp_pkg::BYTE_ONE;
      cmd_o.lo_byte = wcp_pkg::BYTE_ONES << up_shift;
    end

    prev_page_d  = prev_page_q;
    prev_shift_d = prev_shift_q;
    prev_mask_d  = prev_mask_q;
    if (push_o) begin
      prev_page_d  = cur_page;
      prev_shift_d = cur_shift;
      prev_mask_d  = cur_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_page_q  <= '0;
      prev_shift_q <= '0;
      prev_mask_q  <= wcp_pkg::BYTE_ZERO;
    end else begin
      prev_page_q  <= prev_page_d;
      prev_shift_q <= prev_shift_d;
      prev_mask_q  <= prev_mask_d;
    end
  end

endmodule

### rtl/core/wcp_queue.sv
// ----------------------------------------------------------------------------
// wcp_queue
// Short command queue between the classifier and the write sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wcp_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output wcp_pkg::cmd_t      cmd_o,
  output wcp_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (wcp_pkg::QDEPTH > 1) ? $clog2(wcp_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(wcp_pkg::QDEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(wcp_pkg::QDEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(wcp_pkg::QDEPTH - 1);

  wcp_pkg::cmd_t   entry_q [wcp_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == DepthCnt);
  assign status_o.empty = (count_q == '0);
  assign cmd_o          = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `WCP_ASSERT(a_no_overflow, !(push_i && status_o.full), "push into full queue")
  `WCP_ASSERT(a_no_underflow, !(pop_i && status_o.empty), "pop from empty queue")
  `WCP_ASSERT_IMP(a_ptr_gap, status_o.empty || status_o.full, wr_ptr_q == rd_ptr_q,
                  "queue pointers disagree with fill count")

endmodule

### rtl/core/wcp_back.sv
// ----------------------------------------------------------------------------
// wcp_back
// Write sequencer: emits line bytes, then clears the next column.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wcp_pkg::q_status_t q_status_i,
  input  wcp_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wcp_pkg::out_t      out_data_o
);

  wcp_pkg::back_state_e       state_q, state_d;
  wcp_pkg::cmd_t              cmd_q, cmd_d;
  logic [wcp_pkg::PAGE_W-1:0] pg_q, pg_d;
  logic                       out_valid_q, out_valid_d;
  wcp_pkg::out_t              out_q, out_d;

  logic                       slot_free;
  logic [wcp_pkg::COL_W-1:0]  next_col;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign next_col    = (cmd_q.column == wcp_pkg::LAST_COL) ? '0
                     : cmd_q.column + wcp_pkg::COL_W'(1);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pg_d        = pg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;

    unique case (state_q)
      wcp_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          pg_d    = cmd_i.hi_page;
          state_d = wcp_pkg::ST_LINE;
        end
      end
      wcp_pkg::ST_LINE: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.page       = pg_q;
          out_d.out_column = cmd_q.column;
          out_d.last       = 1'b0;
          if (pg_q == cmd_q.hi_page) begin
            out_d.pixels = cmd_q.hi_byte;
          end else if (pg_q == cmd_q.lo_page) begin
            out_d.pixels = cmd_q.lo_byte;
          end else begin
            out_d.pixels = wcp_pkg::BYTE_ONES;
          end
          if (pg_q == cmd_q.lo_page) begin
            pg_d    = '0;
            state_d = wcp_pkg::ST_CLEAR;
          end else begin
            pg_d = pg_q - wcp_pkg::PAGE_W'(1);
          end
        end
      end
      wcp_pkg::ST_CLEAR: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.page       = pg_q;
          out_d.out_column = next_col;
          out_d.pixels     = wcp_pkg::BYTE_ZERO;
          out_d.last       = (pg_q == wcp_pkg::LAST_PAGE);
          if (pg_q == wcp_pkg::LAST_PAGE) begin
            // chain straight into the next queued sample
            if (!q_status_i.empty) begin
              pop_o   = 1'b1;
              cmd_d   = cmd_i;
              pg_d    = cmd_i.hi_page;
              state_d = wcp_pkg::ST_LINE;
            end else begin
              state_d = wcp_pkg::ST_IDLE;
            end
          end else begin
            pg_d = pg_q + wcp_pkg::PAGE_W'(1);
          end
        end
      end
      default: begin
        state_d = wcp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wcp_pkg::ST_IDLE;
      pg_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pg_q        <= pg_d;
      out_valid_q <= out_valid_d;
    end
  end

  `WCP_ASSERT_IMP(a_line_range, state_q == wcp_pkg::ST_LINE,
                  pg_q <= cmd_q.hi_page && pg_q >= cmd_q.lo_page,
                  "line page outside segment")
  `WCP_ASSERT_IMP(a_last_ends, out_valid_q && out_ready_i && out_q.last,
                  out_q.page == wcp_pkg::LAST_PAGE && out_q.pixels == wcp_pkg::BYTE_ZERO,
                  "last flag on a write other than the final clear")
  `WCP_ASSERT(a_out_hold,
              !$past(out_valid_q && !out_ready_i) || (out_valid_q && $stable(out_q)),
              "waiting write dropped or changed")

endmodule

### rtl/core/waveform_column_plotter_unit.sv
// ----------------------------------------------------------------------------
// waveform_column_plotter_unit
// Draws one vertical waveform segment per sample and blanks the next column.
// ----------------------------------------------------------------------------
// A sample goes through the queue and the sequencer's command and output registers.
// Throughput: 1 to 8 line writes plus 8 clear writes per sample, one write a
// cycle from the sequencer's output register while the output is ready and
// commands are queued; an idle sequencer first pops the next command.
// A two-entry command queue lets samples be taken while writes drain.
// Reset clears the previous point (page 0, shift 0, mask 0) and the queue.
module waveform_column_plotter_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wcp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wcp_pkg::out_t  out_data_o
);

  wcp_pkg::q_status_t q_status;
  wcp_pkg::cmd_t      front_cmd;
  wcp_pkg::cmd_t      head_cmd;
  logic               push;
  logic               pop;

  wcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  wcp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  wcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/sv/tb_waveform_column_plotter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_column_plotter_unit
// Feeds samples into the plotter and checks every page write it emits.
// A short table covers end points, page crossings both ways and column wrap.
// Random waveform-like samples follow. Both sides idle in bursts, and the
// output side holds off once for a long stretch. Writes are checked in order
// against a local model of the line drawing and column clearing.
// ----------------------------------------------------------------------------
module tb_waveform_column_plotter_unit;

  localparam int unsigned PAGES   = wcp_pkg::PAGES;
  localparam int unsigned COLUMNS = wcp_pkg::COLUMNS;
  localparam int unsigned PAGE_W  = wcp_pkg::PAGE_W;
  localparam int unsigned COL_W   = wcp_pkg::COL_W;
  localparam int unsigned Y_W     = wcp_pkg::Y_W;
  localparam int unsigned BYTE_W  = wcp_pkg::BYTE_W;

  localparam int unsigned RANDOM_SAMPLES = 287;
  localparam int unsigned CALM_TAIL      = 40;
  localparam int unsigned HOLD_AFTER     = 600;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int          Y_MAX          = (1 << Y_W) - 1;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [Y_W-1:0]    sample;
    logic              known;
    logic [PAGE_W-1:0] line_page;
    logic [BYTE_W-1:0] line_byte;
  } directed_row_t;

  localparam int unsigned N_DIRECTED = 23;
  // line byte typed in only where the line is a single byte in one page
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{7'd0,   6'd63, 1'b1, 3'd0, 8'h01},  // first point, previous mask still zero
    '{7'd127, 6'd56, 1'b1, 3'd0, 8'hFF},  // top page, full span; next column wraps
    '{7'd5,   6'd63, 1'b1, 3'd0, 8'h7F},  // same page, moving up
    '{7'h2A,  6'd0,  1'b0, 3'd0, 8'h00},  // full height drop to the bottom row
    '{7'h55,  6'd63, 1'b0, 3'd0, 8'h00},  // full height rise
    '{7'h40,  6'd0,  1'b0, 3'd0, 8'h00},
    '{7'h41,  6'd0,  1'b1, 3'd7, 8'h80},  // flat line
    '{7'h42,  6'd7,  1'b1, 3'd7, 8'h7F},
    '{7'h43,  6'd1,  1'b1, 3'd7, 8'h7F},
    '{7'h44,  6'd8,  1'b0, 3'd0, 8'h00},  // adjacent pages, nothing between
    '{7'h45,  6'd15, 1'b0, 3'd0, 8'h00},
    '{7'h46,  6'd16, 1'b0, 3'd0, 8'h00},
    '{7'h47,  6'd56, 1'b0, 3'd0, 8'h00},
    '{7'h48,  6'd0,  1'b0, 3'd0, 8'h00},  // upper end at bit 7, its byte shifts out
    '{7'h49,  6'd31, 1'b0, 3'd0, 8'h00},
    '{7'h4A,  6'd32, 1'b0, 3'd0, 8'h00},
    '{7'h4B,  6'd47, 1'b0, 3'd0, 8'h00},
    '{7'h4C,  6'd48, 1'b0, 3'd0, 8'h00},
    '{7'h4D,  6'd55, 1'b0, 3'd0, 8'h00},
    '{7'h7E,  6'd20, 1'b0, 3'd0, 8'h00},
    '{7'h7F,  6'd28, 1'b0, 3'd0, 8'h00},
    '{7'h00,  6'd63, 1'b0, 3'd0, 8'h00},
    '{7'h01,  6'd62, 1'b1, 3'd0, 8'h03}
  };

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  wcp_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  wcp_pkg::out_t out_data;

  // previous point of the trace
  logic [PAGE_W-1:0] trace_page  = '0;
  logic [2:0]        trace_shift = '0;
  logic [BYTE_W-1:0] trace_mask  = '0;

  wcp_pkg::out_t pending_writes[$];
  int unsigned   writes_seen = 0;
  int unsigned   errors      = 0;
  bit            calm_tail   = 1'b0;
  bit            hold_done   = 1'b0;

  always #10 clk = ~clk;

  waveform_column_plotter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic void push_write(input logic [PAGE_W-1:0] pg,
                                     input logic [COL_W-1:0] col,
                                     input logic [BYTE_W-1:0] px);
    wcp_pkg::out_t w;
    w.page       = pg;
    w.out_column = col;
    w.pixels     = px;
    w.last       = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic void plot_sample(input wcp_pkg::in_t s);
    int                band;
    int                lo;
    int                hi;
    logic [PAGE_W-1:0] cur_page;
    logic [2:0]        cur_shift;
    logic [BYTE_W-1:0] cur_mask;
    logic [BYTE_W-1:0] lo_byte;
    logic [BYTE_W-1:0] hi_byte;
    logic [BYTE_W-1:0] px;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  next_col;
    wcp_pkg::out_t     w;
    col  = COL_W'(int'(s.column) % int'(COLUMNS));
    band = int'(s.sample) >> 3;
    if (band > int'(PAGES) - 1) band = int'(PAGES) - 1;
    cur_page  = PAGE_W'(int'(PAGES) - 1 - band);
    cur_shift = wcp_pkg::BIT_TOP - s.sample[2:0];
    cur_mask  = wcp_pkg::BYTE_ONE << cur_shift;
    if (cur_page == trace_page) begin
      if (cur_shift == trace_shift) px = cur_mask;
      else if (cur_shift > trace_shift) px = (cur_mask - trace_mask) | cur_mask;
      else px = trace_mask - cur_mask;
      push_write(cur_page, col, px);
    end else begin
      // walk from the lower end's page (larger number) up to the other end
      if (trace_page > cur_page) begin
        lo      = int'(trace_page);
        hi      = int'(cur_page);
        lo_byte = trace_mask - wcp_pkg::BYTE_ONE;
        hi_byte = wcp_pkg::BYTE_ONES << cur_shift;
      end else begin
        lo      = int'(cur_page);
        hi      = int'(trace_page);
        lo_byte = (cur_mask << 1) - wcp_pkg::BYTE_ONE;
        hi_byte = BYTE_W'(16'(wcp_pkg::BYTE_ONES) << (int'(trace_shift) + 1));
      end
      push_write(PAGE_W'(lo), col, lo_byte);
      for (int p = lo - 1; p > hi; p--) push_write(PAGE_W'(p), col, wcp_pkg::BYTE_ONES);
      push_write(PAGE_W'(hi), col, hi_byte);
    end
    trace_page  = cur_page;
    trace_shift = cur_shift;
    trace_mask  = cur_mask;
    next_col = COL_W'((int'(col) + 1) % int'(COLUMNS));
    for (int p = 0; p < int'(PAGES); p++)
      push_write(PAGE_W'(p), next_col, wcp_pkg::BYTE_ZERO);
    w = pending_writes[$];
    w.last = 1'b1;
    pending_writes[$] = w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: write %0d %s: got 0x%0h, want 0x%0h",
             $time, writes_seen, what, got, want);
    errors++;
  endtask

  // offer one sample, hold it until the transfer, then predict its writes
  task automatic offer_sample(input wcp_pkg::in_t s, input bit known,
                              input logic [PAGE_W-1:0] pg,
                              input logic [BYTE_W-1:0] px);
    int unsigned   base;
    wcp_pkg::out_t w;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    base = pending_writes.size();
    plot_sample(s);
    if (known) begin
      w = pending_writes[base];
      w.page   = pg;
      w.pixels = px;
      pending_writes[base] = w;
    end
  endtask

  task automatic idle_burst();
    in_valid <= 1'b0;
    in_data  <= {COL_W'($urandom), Y_W'($urandom)};
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  always @(posedge clk) begin
    wcp_pkg::out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("with nothing pending", int'(out_data), 0);
      end else begin
        w = pending_writes.pop_front();
        if (out_data.page != w.page)
          report_mismatch("page", int'(out_data.page), int'(w.page));
        if (out_data.out_column != w.out_column)
          report_mismatch("column", int'(out_data.out_column), int'(w.out_column));
        if (out_data.pixels != w.pixels)
          report_mismatch("pixels", int'(out_data.pixels), int'(w.pixels));
        if (out_data.last != w.last)
          report_mismatch("last", int'(out_data.last), int'(w.last));
      end
      writes_seen++;
    end
  end

  // output side: short random stalls, one long hold-off
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && writes_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm_tail && ((writes_seen / 150) % 3 != 2) &&
                   $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    wcp_pkg::in_t s;
    int           col;
    int           y;
    int           col_prev;
    int           y_prev;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      s.column = DIRECTED[i].column;
      s.sample = DIRECTED[i].sample;
      offer_sample(s, DIRECTED[i].known, DIRECTED[i].line_page, DIRECTED[i].line_byte);
    end
    // let the plotter drain completely before the random part
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);

    col_prev = 1;
    y_prev   = 62;
    for (int i = 0; i < int'(RANDOM_SAMPLES); i++) begin
      calm_tail = (i >= int'(RANDOM_SAMPLES - CALM_TAIL));
      if (!calm_tail && ((i / 40) % 3 != 1) && $urandom_range(0, 3) == 0) idle_burst();
      // mostly a sweep across the screen, sometimes a jump
      if ($urandom_range(0, 2) != 0) col = (col_prev + 1) % int'(COLUMNS);
      else col = int'($urandom_range(0, COLUMNS - 1));
      case ($urandom_range(0, 9)) inside
        [0:4]:   y = y_prev + int'($urandom_range(0, 20)) - 10;
        [5:7]:   y = int'($urandom_range(0, Y_MAX));
        8:       y = ($urandom_range(0, 1) != 0) ? Y_MAX : 0;
        default: y = 8 * int'($urandom_range(0, 7)) +
                     (($urandom_range(0, 1) != 0) ? 7 : 0);
      endcase
      if (y < 0) y = 0;
      if (y > Y_MAX) y = Y_MAX;
      s.column = COL_W'(col);
      s.sample = Y_W'(y);
      offer_sample(s, 1'b0, '0, '0);
      col_prev = col;
      y_prev   = y;
    end
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/wcp_pkg.sv
rtl/core/wcp_front.sv
rtl/core/wcp_queue.sv
rtl/core/wcp_back.sv
rtl/core/waveform_column_plotter_unit.sv
tb/sv/tb_waveform_column_plotter_unit.sv
